// ----- rtl/core/deq_pkg.sv -----
// Package for the double-ended queue: item structs, command and status codes,
// and default sizes. No dependencies.
`default_nettype none

package deq_pkg;

  // Default ring size and stored word width
  localparam int unsigned DEQ_DEPTH      = 16;
  localparam int unsigned DEQ_DATA_WIDTH = 64;

  // Command codes; codes 6 and 7 behave as query
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REVERSE    = 3'd4,
    CMD_QUERY      = 3'd5
  } cmd_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // Input item
  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] value;
  } deq_in_t;

  // Result item
  typedef struct packed {
    logic [63:0] front_value;
    logic [63:0] back_value;
    logic [4:0]  count;
    logic        empty_res;
    logic [1:0]  status;
  } deq_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/deq_ram.sv -----
// Generic RAM: one write port, two read ports, read data registered.
// No dependencies.
`default_nettype none

module deq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/double_ended_queue_top.sv -----
// Top level of the double-ended queue: control sequencer, ring pointers and
// output register. Depends on deq_pkg and deq_ram.
`default_nettype none

// A double-ended queue of DATA_WIDTH-bit words held in a ring of DEPTH entries
// in a RAM with two registered read ports. Each command item yields one result
// item with the logical front and back words, the entry count, an empty flag
// and a status (overflow on a push when full, underflow on a pop or reverse
// when empty; those change nothing). The accept cycle updates head, count and
// orientation and writes a pushed word, the next cycle reads the front and back
// slots from the RAM, and a final step loads the result register; that step
// stretches while an earlier result still waits in the output register. A new
// item is taken while a finished result waits to be taken. After reset the
// queue is empty and no clearing pass is needed.
module double_ended_queue_top import deq_pkg::*; #(
  parameter int unsigned DEPTH      = DEQ_DEPTH,
  parameter int unsigned DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire deq_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output deq_out_t     out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d;
  status_e       status_q, status_d;
  logic          out_valid_q, out_valid_d;
  deq_out_t      out_q, out_d;

  logic            accept;
  logic            full, empty;
  logic            phys_front;
  logic [AW-1:0]   head_dec, head_inc;
  logic [AW:0]     tail_sum, last_sum;
  logic [AW-1:0]   tail_slot, last_slot;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [DATA_WIDTH-1:0] rd_front, rd_back;
  logic [DATA_WIDTH-1:0] log_front, log_back;
  logic            out_load;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // Ring neighbors of the head
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

  // Slot after the last entry (push at the physical back)
  assign tail_sum  = (AW + 1)'(head_q) + (AW + 1)'(count_q);
  assign tail_slot = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
                                                    : AW'(tail_sum);

  // Slot of the last entry (read at the physical back)
  assign last_sum  = tail_sum - (AW + 1)'(1);
  assign last_slot = (last_sum >= (AW + 1)'(DEPTH)) ? AW'(last_sum - (AW + 1)'(DEPTH))
                                                    : AW'(last_sum);

  // Apply the command on accept
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    rev_d      = rev_q;
    status_d   = status_q;
    mem_we     = 1'b0;
    mem_waddr  = tail_slot;
    phys_front = 1'b0;
    if (accept) begin
      status_d = ST_OK;
      unique case (in_data_i.command)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          phys_front = (in_data_i.command == CMD_PUSH_FRONT) != rev_q;
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + CW'(1);
            if (phys_front) begin
              head_d    = head_dec;
              mem_waddr = head_dec;
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          phys_front = (in_data_i.command == CMD_POP_FRONT) != rev_q;
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            count_d = count_q - CW'(1);
            if (phys_front) begin
              head_d = head_inc;
            end
          end
        end
        CMD_REVERSE: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            rev_d = !rev_q;
          end
        end
        default: begin
          // query and unused codes leave the state alone
        end
      endcase
    end
  end

  // Ring storage; read addresses follow the updated pointers
  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (in_data_i.value[DATA_WIDTH-1:0]),
    .raddr_a_i (head_q),
    .rdata_a_o (rd_front),
    .raddr_b_i (last_slot),
    .rdata_b_o (rd_back)
  );

  // Orientation picks logical front and back
  assign log_front = rev_q ? rd_back : rd_front;
  assign log_back  = rev_q ? rd_front : rd_back;

  // Result build and output register
  assign out_load = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d       = 1'b1;
      out_d.front_value = empty ? '0 : 64'(log_front);
      out_d.back_value  = empty ? '0 : 64'(log_back);
      out_d.count       = 5'(count_q);
      out_d.empty_res   = empty;
      out_d.status      = status_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_READ;
      S_READ:  state_d = S_RESP;
      S_RESP:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
